### src/gdc_pkg.sv
package gdc_pkg;

  localparam int unsigned MAP_DIM       = 64;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned MAX_STEPS     = 128;

  localparam int unsigned CELL_W = $clog2(MAP_DIM);
  localparam int unsigned ADDR_W = 2 * CELL_W;
  localparam int unsigned CNT_W  = $clog2(MAX_STEPS + 1);

  // shared divider: widest dividend is (num << FRAC_BITS), widest divisor is perp
  localparam int unsigned DVD_W = 40;
  localparam int unsigned DVS_W = 24;

  localparam logic [23:0] PERP_MAX   = 24'hFFFFFF;
  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
  localparam logic [15:0] HALF_SCR   = 16'(SCREEN_HEIGHT / 2);

  localparam logic [1:0] FACE_EAST  = 2'd0;
  localparam logic [1:0] FACE_WEST  = 2'd1;
  localparam logic [1:0] FACE_SOUTH = 2'd2;
  localparam logic [1:0] FACE_NORTH = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

endpackage

### src/gdc_if.sv
interface gdc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [5:0]         cell_col;
  logic [5:0]         cell_row;
  logic               cell_is_wall;
  logic [21:0]        pos_x;
  logic [21:0]        pos_y;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;

  modport source (output valid, kind, cell_col, cell_row, cell_is_wall, pos_x, pos_y,
                  dir_x, dir_y, input ready);
  modport sink (input valid, kind, cell_col, cell_row, cell_is_wall, pos_x, pos_y,
                dir_x, dir_y, output ready);
endinterface

interface gdc_out_if;
  logic               valid;
  logic               ready;
  logic               hit_found;
  logic [23:0]        wall_dist;
  logic [15:0]        wall_frac;
  logic [1:0]         face;
  logic [15:0]        column_height;
  logic signed [15:0] column_top;

  modport source (output valid, hit_found, wall_dist, wall_frac, face, column_height,
                  column_top, input ready);
  modport sink (input valid, hit_found, wall_dist, wall_frac, face, column_height,
                column_top, output ready);
endinterface

### src/gdc_ram.sv
module gdc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### src/gdc_div.sv
module gdc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gdc_pkg::DVD_W-1:0]  dividend_i,
  input  logic [gdc_pkg::DVS_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [gdc_pkg::DVD_W-1:0]  quot_o
);

  localparam int unsigned IterW = $clog2(gdc_pkg::DVD_W + 1);

  logic [gdc_pkg::DVD_W-1:0] q_q;
  logic [gdc_pkg::DVS_W-1:0] rem_q;
  logic [gdc_pkg::DVS_W-1:0] dvs_q;
  logic [IterW-1:0]          iter_q;
  logic                      busy_q;
  logic                      done_q;
  logic [gdc_pkg::DVS_W:0]   trial;
  logic                      fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, q_q[gdc_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      q_q    <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        q_q    <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        iter_q <= '0;
      end else if (busy_q) begin
        rem_q  <= fits ? gdc_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[gdc_pkg::DVS_W-1:0];
        q_q    <= {q_q[gdc_pkg::DVD_W-2:0], fits};
        iter_q <= iter_q + 1'b1;
        if (iter_q == IterW'(gdc_pkg::DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

### src/grid_ray_dda_caster.sv
// Grid ray caster.
// req_i takes requests: kind 0 writes one cell of the 64x64 wall map, kind 1
// casts one ray from pos_x/pos_y along dir_x/dir_y. res_o returns one result per
// cast request and nothing for a map write.
// A map write goes into the map RAM as it is accepted. A cast runs on one shared
// restoring divider and one shared multiplier: two step-length divisions, two
// side-length products, then up to 128 grid steps (each step waits on the map RAM
// read), then, if a wall is hit, a distance division, a fraction product and a
// height division. Every division is skipped for a zero divisor. A cast holds the
// block until its result is loaded into the output register.
// After reset the map RAM is cleared one cell per cycle, and no request is taken
// until that pass ends.
// A result sits in the output register until res_o.ready; the next request is
// taken meanwhile, but its result waits until the register is free.
module grid_ray_dda_caster (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdc_in_if.sink    req_i,
  gdc_out_if.source res_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIVX = 4'd2;
  localparam logic [3:0] S_DIVY = 4'd3;
  localparam logic [3:0] S_MULX = 4'd4;
  localparam logic [3:0] S_MULY = 4'd5;
  localparam logic [3:0] S_STEP = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_DIVP = 4'd8;
  localparam logic [3:0] S_FRAC = 4'd9;
  localparam logic [3:0] S_DIVH = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam int unsigned FB = gdc_pkg::FRAC_BITS;

  logic [3:0]                  state_q;
  logic [gdc_pkg::ADDR_W-1:0]  clr_q;
  logic [21:0]                 px_q, py_q;
  logic signed [17:0]          dirx_q, diry_q;
  logic [17:0]                 magx_q, magy_q;
  logic [36:0]                 dx_q, dy_q;
  logic [43:0]                 sx_q, sy_q;
  logic signed [7:0]           mx_q, my_q;
  logic                        side_q;
  logic [gdc_pkg::CNT_W-1:0]   cnt_q;
  logic                        outside_q;
  logic                        hit_q;
  logic [23:0]                 perp_q;
  logic [15:0]                 frac_q;
  logic [15:0]                 hgt_q;
  logic                        launch_q;
  logic                        ovld_q;
  logic                        o_hit_q;
  logic [23:0]                 o_perp_q;
  logic [15:0]                 o_frac_q;
  logic [1:0]                  o_face_q;
  logic [15:0]                 o_hgt_q;
  logic [15:0]                 o_top_q;

  logic                        in_acc;
  logic                        out_load;
  logic                        ram_we;
  logic [gdc_pkg::ADDR_W-1:0]  ram_addr;
  logic                        ram_wdata;
  logic                        ram_rdata;

  logic                        div_go, div_busy, div_done;
  logic [gdc_pkg::DVD_W-1:0]   div_dvd, div_q;
  logic [gdc_pkg::DVS_W-1:0]   div_dvs;

  logic [32:0]                 mul_a;
  logic signed [17:0]          mul_b;
  logic signed [51:0]          prod;

  logic [16:0]                 fx, fy;
  logic                        go_x;
  logic signed [7:0]           nmx, nmy, mx1, my1;
  logic signed [24:0]          nx, ny;
  logic [22:0]                 num;
  logic [17:0]                 mag_sel;
  logic [1:0]                  face;

  assign in_acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_OUT) && (!ovld_q || res_o.ready);

  assign fx = dirx_q[17] ? {1'b0, px_q[FB-1:0]} : 17'h10000 - {1'b0, px_q[FB-1:0]};
  assign fy = diry_q[17] ? {1'b0, py_q[FB-1:0]} : 17'h10000 - {1'b0, py_q[FB-1:0]};

  // next cell of the walk; ties step along y
  assign go_x = sx_q < sy_q;
  assign nmx  = go_x ? (dirx_q[17] ? mx_q - 8'sd1 : mx_q + 8'sd1) : mx_q;
  assign nmy  = go_x ? my_q : (diry_q[17] ? my_q - 8'sd1 : my_q + 8'sd1);

  // distance from the player to the entered wall line along the hit axis
  assign mx1 = mx_q + 8'sd1;
  assign my1 = my_q + 8'sd1;
  assign nx  = dirx_q[17] ? $signed({3'b0, px_q}) - $signed({mx1[7], mx1, 16'd0})
                          : $signed({mx_q[7], mx_q, 16'd0}) - $signed({3'b0, px_q});
  assign ny  = diry_q[17] ? $signed({3'b0, py_q}) - $signed({my1[7], my1, 16'd0})
                          : $signed({my_q[7], my_q, 16'd0}) - $signed({3'b0, py_q});
  assign num     = side_q ? ny[22:0] : nx[22:0];
  assign mag_sel = side_q ? magy_q : magx_q;

  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    div_go  = 1'b0;
    case (state_q)
      S_DIVX: begin
        div_dvd = gdc_pkg::DVD_W'(1) << (2 * FB);
        div_dvs = gdc_pkg::DVS_W'(magx_q);
        div_go  = (magx_q != '0) && !launch_q;
      end
      S_DIVY: begin
        div_dvd = gdc_pkg::DVD_W'(1) << (2 * FB);
        div_dvs = gdc_pkg::DVS_W'(magy_q);
        div_go  = (magy_q != '0) && !launch_q;
      end
      S_DIVP: begin
        div_dvd = {1'b0, num, 16'd0};
        div_dvs = gdc_pkg::DVS_W'(mag_sel);
        div_go  = (mag_sel != '0) && !launch_q;
      end
      S_DIVH: begin
        div_dvd = gdc_pkg::DVD_W'(gdc_pkg::SCREEN_HEIGHT) << FB;
        div_dvs = perp_q;
        div_go  = (perp_q != '0) && !launch_q;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_a = dx_q[32:0];
    mul_b = $signed({1'b0, fx});
    case (state_q)
      S_MULY: begin
        mul_a = dy_q[32:0];
        mul_b = $signed({1'b0, fy});
      end
      S_FRAC: begin
        mul_a = {9'd0, perp_q};
        mul_b = side_q ? dirx_q : diry_q;
      end
      default: begin
        mul_a = dx_q[32:0];
      end
    endcase
  end

  assign prod = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    if (!side_q) begin
      face = (!dirx_q[17] && dirx_q != '0) ? gdc_pkg::FACE_EAST : gdc_pkg::FACE_WEST;
    end else begin
      face = (!diry_q[17] && diry_q != '0) ? gdc_pkg::FACE_SOUTH : gdc_pkg::FACE_NORTH;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = {nmy[gdc_pkg::CELL_W-1:0], nmx[gdc_pkg::CELL_W-1:0]};
    case (state_q)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      S_IDLE: begin
        ram_we    = in_acc && (req_i.kind == gdc_pkg::KIND_WRITE);
        ram_wdata = req_i.cell_is_wall;
        ram_addr  = {req_i.cell_row, req_i.cell_col};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  gdc_ram #(
    .Width (1),
    .Depth (gdc_pkg::MAP_DIM * gdc_pkg::MAP_DIM)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  gdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      launch_q  <= 1'b0;
      ovld_q    <= 1'b0;
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      side_q    <= 1'b0;
      outside_q <= 1'b0;
    end else begin
      if (div_go) begin
        launch_q <= 1'b1;
      end
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && req_i.kind == gdc_pkg::KIND_CAST) begin
            px_q    <= req_i.pos_x;
            py_q    <= req_i.pos_y;
            dirx_q  <= req_i.dir_x;
            diry_q  <= req_i.dir_y;
            magx_q  <= req_i.dir_x[17] ? 18'(-req_i.dir_x) : 18'(req_i.dir_x);
            magy_q  <= req_i.dir_y[17] ? 18'(-req_i.dir_y) : 18'(req_i.dir_y);
            mx_q    <= $signed({2'b0, req_i.pos_x[21:FB]});
            my_q    <= $signed({2'b0, req_i.pos_y[21:FB]});
            cnt_q   <= '0;
            side_q  <= 1'b0;
            state_q <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (magx_q == '0) begin
            dx_q    <= 37'(1) << 36;
            state_q <= S_DIVY;
          end else if (div_done) begin
            dx_q     <= {4'd0, div_q[32:0]};
            launch_q <= 1'b0;
            state_q  <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (magy_q == '0) begin
            dy_q    <= 37'(1) << 36;
            state_q <= S_MULX;
          end else if (div_done) begin
            dy_q     <= {4'd0, div_q[32:0]};
            launch_q <= 1'b0;
            state_q  <= S_MULX;
          end
        end
        S_MULX: begin
          sx_q    <= (magx_q == '0) ? {7'd0, fx, 20'd0} : {10'd0, prod[49:FB]};
          state_q <= S_MULY;
        end
        S_MULY: begin
          sy_q    <= (magy_q == '0) ? {7'd0, fy, 20'd0} : {10'd0, prod[49:FB]};
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (cnt_q == gdc_pkg::CNT_W'(gdc_pkg::MAX_STEPS)) begin
            hit_q   <= 1'b0;
            state_q <= S_OUT;
          end else begin
            if (go_x) begin
              sx_q   <= sx_q + 44'(dx_q);
              side_q <= 1'b0;
            end else begin
              sy_q   <= sy_q + 44'(dy_q);
              side_q <= 1'b1;
            end
            mx_q      <= nmx;
            my_q      <= nmy;
            cnt_q     <= cnt_q + 1'b1;
            outside_q <= nmx[7] || nmy[7] || nmx > 8'(gdc_pkg::MAP_DIM - 1)
                         || nmy > 8'(gdc_pkg::MAP_DIM - 1);
            state_q   <= S_CHK;
          end
        end
        S_CHK: begin
          // cells off the map count as wall
          if (outside_q || ram_rdata) begin
            hit_q    <= 1'b1;
            launch_q <= 1'b0;
            state_q  <= S_DIVP;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_DIVP: begin
          if (mag_sel == '0) begin
            perp_q  <= gdc_pkg::PERP_MAX;
            state_q <= S_FRAC;
          end else if (div_done) begin
            perp_q   <= (|div_q[39:24]) ? gdc_pkg::PERP_MAX : div_q[23:0];
            launch_q <= 1'b0;
            state_q  <= S_FRAC;
          end
        end
        S_FRAC: begin
          frac_q  <= (side_q ? px_q[FB-1:0] : py_q[FB-1:0]) + prod[31:FB];
          state_q <= S_DIVH;
        end
        S_DIVH: begin
          if (perp_q == '0) begin
            hgt_q   <= gdc_pkg::HEIGHT_MAX;
            state_q <= S_OUT;
          end else if (div_done) begin
            hgt_q    <= (|div_q[39:16]) ? gdc_pkg::HEIGHT_MAX : div_q[15:0];
            launch_q <= 1'b0;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            o_hit_q  <= hit_q;
            o_perp_q <= hit_q ? perp_q : gdc_pkg::PERP_MAX;
            o_frac_q <= hit_q ? frac_q : 16'd0;
            o_face_q <= hit_q ? face : gdc_pkg::FACE_EAST;
            o_hgt_q  <= hit_q ? hgt_q : 16'd0;
            o_top_q  <= gdc_pkg::HALF_SCR - (hit_q ? {1'b0, hgt_q[15:1]} : 16'd0);
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid         = ovld_q;
  assign res_o.hit_found     = o_hit_q;
  assign res_o.wall_dist     = o_perp_q;
  assign res_o.wall_frac     = o_frac_q;
  assign res_o.face          = o_face_q;
  assign res_o.column_height = o_hgt_q;
  assign res_o.column_top    = $signed(o_top_q);

`ifndef SYNTHESIS
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !div_busy)
    else $error("divider busy while taking requests");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.hit_found) |->
      (res_o.wall_dist == gdc_pkg::PERP_MAX && res_o.column_height == 16'd0))
    else $error("no-hit result carries distance");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (cnt_q != '0 && cnt_q <= gdc_pkg::CNT_W'(gdc_pkg::MAX_STEPS)))
    else $error("step count out of bound");
`endif

endmodule
